@@ rtl/url_byte_stream_parser_core_defines.svh @@
`ifndef URL_BYTE_STREAM_PARSER_CORE_DEFINES_SVH
`define URL_BYTE_STREAM_PARSER_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UBSP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define UBSP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/ubsp_pkg.sv @@
package ubsp_pkg;

  localparam int COUNT_WIDTH = 8;
  localparam int BYTE_W      = 8;
  localparam int KIND_W      = 3;
  localparam int INDEX_W     = 8;
  localparam int STATUS_W    = 2;

  localparam logic [BYTE_W-1:0] CH_SLASH  = 8'h2F;
  localparam logic [BYTE_W-1:0] CH_BSLASH = 8'h5C;
  localparam logic [BYTE_W-1:0] CH_QUEST  = 8'h3F;
  localparam logic [BYTE_W-1:0] CH_AMP    = 8'h26;
  localparam logic [BYTE_W-1:0] CH_HASH   = 8'h23;
  localparam logic [BYTE_W-1:0] CH_EQUAL  = 8'h3D;
  localparam logic [BYTE_W-1:0] CH_COLON  = 8'h3A;

  localparam logic [KIND_W-1:0] K_NONE   = 3'd0;
  localparam logic [KIND_W-1:0] K_SCHEME = 3'd1;
  localparam logic [KIND_W-1:0] K_HOST   = 3'd2;
  localparam logic [KIND_W-1:0] K_PATH   = 3'd3;
  localparam logic [KIND_W-1:0] K_KEY    = 3'd4;
  localparam logic [KIND_W-1:0] K_VALUE  = 3'd5;
  localparam logic [KIND_W-1:0] K_FRAG   = 3'd6;

  localparam logic [STATUS_W-1:0] STAT_BUSY   = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_ACCEPT = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_REJECT = 2'd2;

  typedef enum logic [13:0] {
    ST_START      = 14'b00000000000001,
    ST_SCHEME     = 14'b00000000000010,
    ST_SLASH1     = 14'b00000000000100,
    ST_SLASH2     = 14'b00000000001000,
    ST_HOST       = 14'b00000000010000,
    ST_SEG_START  = 14'b00000000100000,
    ST_SEG        = 14'b00000001000000,
    ST_PAIR_START = 14'b00000010000000,
    ST_KEY        = 14'b00000100000000,
    ST_VALUE      = 14'b00001000000000,
    ST_FRAG       = 14'b00010000000000,
    ST_FINISH     = 14'b00100000000000,
    ST_ACCEPTED   = 14'b01000000000000,
    ST_REJECTED   = 14'b10000000000000
  } state_t;

  typedef enum logic [1:0] {
    TOK_NONE = 2'd0,
    TOK_SEG  = 2'd1,
    TOK_PAIR = 2'd2
  } tok_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   out_byte;
    logic [KIND_W-1:0]   field_kind;
    logic                opens_token;
    logic [INDEX_W-1:0]  token_index;
    logic [STATUS_W-1:0] parse_status;
  } result_t;

  function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] c);
    return (c == '1) ? c : c + 1'b1;
  endfunction

  function automatic logic [COUNT_WIDTH-1:0] index_of(input logic [COUNT_WIDTH-1:0] c);
    return (c != '0) ? c - 1'b1 : '0;
  endfunction

endpackage

@@ rtl/ubsp_if.sv @@
interface ubsp_in_if;
  logic                        valid;
  logic                        ready;
  logic [ubsp_pkg::BYTE_W-1:0] data_byte;
  logic                        is_first;
  logic                        is_penultimate;
  logic                        is_last;

  modport source (output valid, output data_byte, output is_first,
                  output is_penultimate, output is_last, input ready);
  modport sink (input valid, input data_byte, input is_first,
                input is_penultimate, input is_last, output ready);
endinterface

interface ubsp_out_if;
  logic                          valid;
  logic                          ready;
  logic [ubsp_pkg::BYTE_W-1:0]   out_byte;
  logic [ubsp_pkg::KIND_W-1:0]   field_kind;
  logic                          opens_token;
  logic [ubsp_pkg::INDEX_W-1:0]  token_index;
  logic [ubsp_pkg::STATUS_W-1:0] parse_status;

  modport source (output valid, output out_byte, output field_kind, output opens_token,
                  output token_index, output parse_status, input ready);
  modport sink (input valid, input out_byte, input field_kind, input opens_token,
                input token_index, input parse_status, output ready);
endinterface

@@ rtl/url_byte_stream_parser_core.sv @@
// a byte accepted into an empty output stage is shown in the next cycle
// throughput: one byte per cycle while the skid entry is empty, bounded by the parse state update loop
// an output register plus one skid entry let a byte in while a result waits
// reset (rst_n low at a clock edge) returns to the start state, clears the
// finishing field and both counts, and empties the output and skid registers
`include "url_byte_stream_parser_core_defines.svh"

module url_byte_stream_parser_core (
  input logic         clk,
  input logic         rst_n,
  ubsp_in_if.sink     in_ch,
  ubsp_out_if.source  out_ch
);

  localparam int CW = ubsp_pkg::COUNT_WIDTH;

  ubsp_pkg::state_t               state_r, state_nxt;
  logic [ubsp_pkg::KIND_W-1:0]    fin_r, fin_nxt;
  logic [CW-1:0]                  seg_r, seg_nxt;
  logic [CW-1:0]                  pair_r, pair_nxt;

  logic                           out_v_r, out_v_nxt;
  logic                           skid_v_r, skid_v_nxt;
  ubsp_pkg::result_t              out_r, out_nxt;
  ubsp_pkg::result_t              skid_r, skid_nxt;
  ubsp_pkg::result_t              res;

  logic                           acc;
  logic                           take;

  ubsp_pkg::state_t               cur;
  ubsp_pkg::state_t               st;
  ubsp_pkg::tok_t                 tok;
  logic [ubsp_pkg::BYTE_W-1:0]    dbyte;
  logic                           pen;
  logic                           last;
  logic [ubsp_pkg::KIND_W-1:0]    kind;
  logic                           opens;
  logic [CW-1:0]                  seg_b, pair_b;
  logic [ubsp_pkg::KIND_W-1:0]    fin_b;
  logic [CW-1:0]                  idx;
  logic [ubsp_pkg::STATUS_W-1:0]  status;

  assign in_ch.ready = !skid_v_r;
  assign acc         = in_ch.valid && !skid_v_r;
  assign take        = out_v_r && out_ch.ready;

  // parse step for the byte at the input
  always_comb begin
    dbyte = in_ch.data_byte;
    last  = in_ch.is_last;
    pen   = in_ch.is_penultimate && !in_ch.is_last;
    cur    = in_ch.is_first ? ubsp_pkg::ST_START : state_r;
    seg_b  = in_ch.is_first ? '0 : seg_r;
    pair_b = in_ch.is_first ? '0 : pair_r;
    fin_b  = in_ch.is_first ? ubsp_pkg::K_NONE : fin_r;

    st       = cur;
    kind     = ubsp_pkg::K_NONE;
    opens    = 1'b0;
    tok      = ubsp_pkg::TOK_NONE;
    seg_nxt  = seg_b;
    pair_nxt = pair_b;
    fin_nxt  = fin_b;

    case (cur)
      ubsp_pkg::ST_START: begin
        if (dbyte == ubsp_pkg::CH_SLASH) begin
          if (pen) begin
            fin_nxt = ubsp_pkg::K_NONE;
            st      = ubsp_pkg::ST_FINISH;
          end else begin
            seg_nxt = ubsp_pkg::sat_inc(seg_b);
            opens   = 1'b1;
            tok     = ubsp_pkg::TOK_SEG;
            st      = ubsp_pkg::ST_SEG;
          end
        end else begin
          kind = ubsp_pkg::K_SCHEME;
          st   = ubsp_pkg::ST_SCHEME;
        end
      end
      ubsp_pkg::ST_SCHEME: begin
        if (dbyte == ubsp_pkg::CH_COLON) st = ubsp_pkg::ST_SLASH1;
        else kind = ubsp_pkg::K_SCHEME;
      end
      ubsp_pkg::ST_SLASH1: begin
        st = (dbyte == ubsp_pkg::CH_SLASH) ? ubsp_pkg::ST_SLASH2 : ubsp_pkg::ST_REJECTED;
      end
      ubsp_pkg::ST_SLASH2: begin
        st = (dbyte == ubsp_pkg::CH_SLASH) ? ubsp_pkg::ST_HOST : ubsp_pkg::ST_REJECTED;
      end
      ubsp_pkg::ST_HOST: begin
        if (pen) begin
          kind    = ubsp_pkg::K_HOST;
          fin_nxt = ubsp_pkg::K_HOST;
          st      = ubsp_pkg::ST_FINISH;
        end else if (dbyte == ubsp_pkg::CH_SLASH || dbyte == ubsp_pkg::CH_BSLASH) begin
          st = ubsp_pkg::ST_SEG_START;
        end else if (dbyte == ubsp_pkg::CH_QUEST || dbyte == ubsp_pkg::CH_AMP) begin
          st = ubsp_pkg::ST_PAIR_START;
        end else if (dbyte == ubsp_pkg::CH_HASH) begin
          st = ubsp_pkg::ST_FRAG;
        end else begin
          kind = ubsp_pkg::K_HOST;
        end
      end
      ubsp_pkg::ST_SEG_START: begin
        if (pen) begin
          fin_nxt = ubsp_pkg::K_NONE;
          st      = ubsp_pkg::ST_FINISH;
        end else if (dbyte != ubsp_pkg::CH_SLASH) begin
          seg_nxt = ubsp_pkg::sat_inc(seg_b);
          opens   = 1'b1;
          kind    = ubsp_pkg::K_PATH;
          st      = ubsp_pkg::ST_SEG;
        end else begin
          // empty path segment
          st = ubsp_pkg::ST_REJECTED;
        end
      end
      ubsp_pkg::ST_SEG: begin
        if (pen) begin
          kind    = ubsp_pkg::K_PATH;
          fin_nxt = ubsp_pkg::K_PATH;
          st      = ubsp_pkg::ST_FINISH;
        end else if (dbyte == ubsp_pkg::CH_SLASH) begin
          st = ubsp_pkg::ST_SEG_START;
        end else if (dbyte == ubsp_pkg::CH_QUEST || dbyte == ubsp_pkg::CH_AMP) begin
          st = ubsp_pkg::ST_PAIR_START;
        end else if (dbyte == ubsp_pkg::CH_HASH) begin
          st = ubsp_pkg::ST_FRAG;
        end else begin
          kind = ubsp_pkg::K_PATH;
        end
      end
      ubsp_pkg::ST_PAIR_START: begin
        if (dbyte == ubsp_pkg::CH_AMP) begin
          st = ubsp_pkg::ST_PAIR_START;
        end else if (pen) begin
          fin_nxt = ubsp_pkg::K_NONE;
          st      = ubsp_pkg::ST_FINISH;
        end else begin
          pair_nxt = ubsp_pkg::sat_inc(pair_b);
          opens    = 1'b1;
          kind     = ubsp_pkg::K_KEY;
          st       = ubsp_pkg::ST_KEY;
        end
      end
      ubsp_pkg::ST_KEY: begin
        if (pen) begin
          kind    = ubsp_pkg::K_KEY;
          fin_nxt = ubsp_pkg::K_KEY;
          st      = ubsp_pkg::ST_FINISH;
        end else if (dbyte == ubsp_pkg::CH_QUEST || dbyte == ubsp_pkg::CH_AMP) begin
          st = ubsp_pkg::ST_PAIR_START;
        end else if (dbyte == ubsp_pkg::CH_HASH) begin
          st = ubsp_pkg::ST_FRAG;
        end else if (dbyte == ubsp_pkg::CH_EQUAL) begin
          st = ubsp_pkg::ST_VALUE;
        end else begin
          kind = ubsp_pkg::K_KEY;
        end
      end
      ubsp_pkg::ST_VALUE: begin
        if (pen) begin
          kind    = ubsp_pkg::K_VALUE;
          fin_nxt = ubsp_pkg::K_VALUE;
          st      = ubsp_pkg::ST_FINISH;
        end else if (dbyte == ubsp_pkg::CH_QUEST || dbyte == ubsp_pkg::CH_AMP) begin
          st = ubsp_pkg::ST_PAIR_START;
        end else if (dbyte == ubsp_pkg::CH_HASH) begin
          st = ubsp_pkg::ST_FRAG;
        end else begin
          kind = ubsp_pkg::K_VALUE;
        end
      end
      ubsp_pkg::ST_FRAG: begin
        kind = ubsp_pkg::K_FRAG;
        if (pen) begin
          fin_nxt = ubsp_pkg::K_FRAG;
          st      = ubsp_pkg::ST_FINISH;
        end
      end
      ubsp_pkg::ST_FINISH: begin
        // final byte joins the field left open by the penultimate byte
        kind = fin_b;
        st   = ubsp_pkg::ST_ACCEPTED;
      end
      ubsp_pkg::ST_ACCEPTED: begin
        st = ubsp_pkg::ST_ACCEPTED;
      end
      ubsp_pkg::ST_REJECTED: begin
        st = ubsp_pkg::ST_REJECTED;
      end
      default: begin
        st = ubsp_pkg::ST_REJECTED;
      end
    endcase

    if (tok == ubsp_pkg::TOK_NONE) begin
      if (kind == ubsp_pkg::K_PATH) tok = ubsp_pkg::TOK_SEG;
      else if (kind == ubsp_pkg::K_KEY || kind == ubsp_pkg::K_VALUE) tok = ubsp_pkg::TOK_PAIR;
    end

    if (last && st != ubsp_pkg::ST_ACCEPTED && st != ubsp_pkg::ST_REJECTED) begin
      st = ubsp_pkg::ST_REJECTED;
    end
    state_nxt = st;

    if (st == ubsp_pkg::ST_FINISH || st == ubsp_pkg::ST_ACCEPTED) status = ubsp_pkg::STAT_ACCEPT;
    else if (st == ubsp_pkg::ST_REJECTED) status = ubsp_pkg::STAT_REJECT;
    else status = ubsp_pkg::STAT_BUSY;

    if (tok == ubsp_pkg::TOK_SEG) idx = ubsp_pkg::index_of(seg_nxt);
    else if (tok == ubsp_pkg::TOK_PAIR) idx = ubsp_pkg::index_of(pair_nxt);
    else idx = '0;

    res.out_byte     = dbyte;
    res.field_kind   = kind;
    res.opens_token  = opens;
    res.token_index  = ubsp_pkg::INDEX_W'(idx);
    res.parse_status = status;
  end

  // output register with one skid entry behind it
  always_comb begin
    out_v_nxt  = out_v_r;
    skid_v_nxt = skid_v_r;
    out_nxt    = out_r;
    skid_nxt   = skid_r;
    if (!out_v_r || take) begin
      if (skid_v_r) begin
        out_nxt    = skid_r;
        out_v_nxt  = 1'b1;
        skid_nxt   = res;
        skid_v_nxt = acc;
      end else begin
        out_nxt   = res;
        out_v_nxt = acc;
      end
    end else if (acc) begin
      skid_nxt   = res;
      skid_v_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ubsp_pkg::ST_START;
      fin_r    <= ubsp_pkg::K_NONE;
      seg_r    <= '0;
      pair_r   <= '0;
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else begin
      if (acc) begin
        state_r <= state_nxt;
        fin_r   <= fin_nxt;
        seg_r   <= seg_nxt;
        pair_r  <= pair_nxt;
      end
      out_v_r  <= out_v_nxt;
      skid_v_r <= skid_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_ch.valid        = out_v_r;
  assign out_ch.out_byte     = out_r.out_byte;
  assign out_ch.field_kind   = out_r.field_kind;
  assign out_ch.opens_token  = out_r.opens_token;
  assign out_ch.token_index  = out_r.token_index;
  assign out_ch.parse_status = out_r.parse_status;

  `UBSP_ASSERT_NOW(a_skid_behind_out, skid_v_r, out_v_r, "skid entry held with empty output stage")
  `UBSP_ASSERT_NEXT(a_direct_load, acc && !out_v_r, out_v_r && out_r.out_byte == $past(in_ch.data_byte), "accepted byte did not reach the output stage")
  `UBSP_ASSERT_NEXT(a_seg_monotonic, acc && !in_ch.is_first, seg_r >= $past(seg_r), "segment count went down without a restart")
  `UBSP_ASSERT_NEXT(a_pair_monotonic, acc && !in_ch.is_first, pair_r >= $past(pair_r), "pair count went down without a restart")

endmodule
